// ===== rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// qte_pkg
// shared widths, stage counts and constants of the imu sample to euler block
// ============================================================================
package qte_pkg;

    // port field widths
    localparam int QIN_W  = 32;
    localparam int RAW_W  = 16;
    localparam int ANG_W  = 16;
    localparam int PIT_W  = 15;
    localparam int RATE_W = 16;
    localparam int ACC_W  = 14;

    // quaternion component after flooring to q28
    localparam int QW  = QIN_W - 2;
    // product width
    localparam int MW  = 2 * QW;
    // wide operand width ahead of atan2 / normalization
    localparam int PW  = 64;
    // operand bound exponent for atan2 and the pitch pair
    localparam int OPB = 30;
    localparam logic signed [PW-1:0] OP_LIM = PW'(1) << OPB;
    // squared operand width
    localparam int SQW = 2 * OPB;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int CW  = OPB + 4;
    localparam int ZW  = 27;
    localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
    localparam int SRCH  = 3;
    localparam int C_LAT = 1 + SRCH + CORDIC_STEPS;

    // pipeline stage numbers
    localparam int ISQRT_STEPS = OPB;
    localparam int S_PITCH_IN  = 9 + ISQRT_STEPS;
    localparam int RY_DLY      = S_PITCH_IN - 2;
    localparam int TOTAL       = S_PITCH_IN + C_LAT + 2;
    localparam int SIDE_DLY    = TOTAL - 3;

    // output limits
    localparam int ROLL_LIM  = 18000;
    localparam int PITCH_LIM = 9000;

    // gyro and accel scaling
    localparam int GYRO_NUM = 25;
    localparam int GYRO_DEN = 41;
    localparam int RECIP41  = 104755299;
    localparam int RECIP_SH = 32;
    localparam int ACC_NUM  = 125;
    localparam int ACC_SH   = 9;

endpackage

// ===== rtl/qte_cordic.sv =====
`timescale 1ns / 1ps
// ============================================================================
// qte_cordic
// pipelined vectoring cordic atan2, degrees q16, with range reduction
// ============================================================================
module qte_cordic (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [qte_pkg::PW-1:0]  i_x,
    input  logic signed [qte_pkg::PW-1:0]  i_y,
    output logic signed [qte_pkg::ZW-1:0]  o_z
);
    import qte_pkg::*;

    localparam int ZD = C_LAT;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } t_xy;

    function automatic logic in_range(input t_xy p);
        in_range = (p.x < OP_LIM) && (p.y < OP_LIM) && (p.y > -OP_LIM);
    endfunction

    // one bit of the binary search for the smallest floor shift
    function automatic t_xy srch_bit(input t_xy p, input int b);
        t_xy t;
        t.x = p.x >>> ((1 << b) - 1);
        t.y = p.y >>> ((1 << b) - 1);
        if (in_range(t)) begin
            srch_bit = p;
        end else begin
            srch_bit.x = p.x >>> (1 << b);
            srch_bit.y = p.y >>> (1 << b);
        end
    endfunction

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        case (i)
            0:  atan_q16 = ZW'(2949120);
            1:  atan_q16 = ZW'(1740967);
            2:  atan_q16 = ZW'(919879);
            3:  atan_q16 = ZW'(466945);
            4:  atan_q16 = ZW'(234379);
            5:  atan_q16 = ZW'(117304);
            6:  atan_q16 = ZW'(58666);
            7:  atan_q16 = ZW'(29335);
            8:  atan_q16 = ZW'(14668);
            9:  atan_q16 = ZW'(7334);
            10: atan_q16 = ZW'(3667);
            11: atan_q16 = ZW'(1833);
            12: atan_q16 = ZW'(917);
            13: atan_q16 = ZW'(458);
            14: atan_q16 = ZW'(229);
            15: atan_q16 = ZW'(115);
            16: atan_q16 = ZW'(57);
            17: atan_q16 = ZW'(29);
            18: atan_q16 = ZW'(14);
            19: atan_q16 = ZW'(7);
            20: atan_q16 = ZW'(4);
            21: atan_q16 = ZW'(2);
            22: atan_q16 = ZW'(1);
            default: atan_q16 = '0;
        endcase
    endfunction

    logic [ZD-1:0]         r_zf;
    t_xy                   r_t;
    logic signed [ZW-1:0]  r_tz;
    t_xy                   r_s  [SRCH];
    logic signed [ZW-1:0]  r_sz [SRCH];
    t_xy                   n_s  [SRCH];
    logic signed [CW-1:0]  r_cx [CORDIC_STEPS];
    logic signed [CW-1:0]  r_cy [CORDIC_STEPS];
    logic signed [ZW-1:0]  r_cz [CORDIC_STEPS];
    logic signed [CW-1:0]  c_x  [CORDIC_STEPS];
    logic signed [CW-1:0]  c_y  [CORDIC_STEPS];
    logic signed [ZW-1:0]  c_z  [CORDIC_STEPS];

    always_comb begin
        for (int s = 0; s < SRCH; s++) begin
            if (s == 0) begin
                n_s[s] = srch_bit(srch_bit(r_t, 5), 4);
            end else begin
                n_s[s] = srch_bit(srch_bit(r_s[s-1], 5 - 2 * s), 4 - 2 * s);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                c_x[i] = CW'(r_s[SRCH-1].x);
                c_y[i] = CW'(r_s[SRCH-1].y);
                c_z[i] = r_sz[SRCH-1];
            end else begin
                c_x[i] = r_cx[i-1];
                c_y[i] = r_cy[i-1];
                c_z[i] = r_cz[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // zero vector gives zero angle
            r_zf <= {r_zf[ZD-2:0], (i_x == '0) && (i_y == '0)};
            // left half plane: turn by 180 degrees
            if (i_x < 0) begin
                r_t.x <= -i_x;
                r_t.y <= -i_y;
                r_tz  <= (i_y >= 0) ? DEG180_Q16 : -DEG180_Q16;
            end else begin
                r_t.x <= i_x;
                r_t.y <= i_y;
                r_tz  <= '0;
            end
            for (int s = 0; s < SRCH; s++) begin
                r_s[s] <= n_s[s];
                if (s == 0) begin
                    r_sz[s] <= r_tz;
                end else begin
                    r_sz[s] <= r_sz[s-1];
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (c_y[i] >= 0) begin
                    r_cx[i] <= c_x[i] + (c_y[i] >>> i);
                    r_cy[i] <= c_y[i] - (c_x[i] >>> i);
                    r_cz[i] <= c_z[i] + atan_q16(i);
                end else begin
                    r_cx[i] <= c_x[i] - (c_y[i] >>> i);
                    r_cy[i] <= c_y[i] + (c_x[i] >>> i);
                    r_cz[i] <= c_z[i] - atan_q16(i);
                end
            end
        end
    end

    assign o_z = r_zf[ZD-1] ? '0 : r_cz[CORDIC_STEPS-1];

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// ============================================================================
// quaternion_to_euler_angles
// imu sample to zyx euler angles in centidegrees, scaled gyro and accel
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  input   | in        | i_valid / o_ready   | quaternion q30, raw gyro, raw accel
//  output  | out       | o_valid / i_ready   | roll, pitch, yaw, rates, accel mg
//
//  one item per cycle sustained while the output is not stalled
//  depth is set by the 30-stage square root in the pitch path followed by
//  the cordic, which roll and yaw wait for in a delay line
//  synchronous active-low reset clears the valid bits only
//  a stall at the output freezes the whole pipe; o_ready follows it
//
module quaternion_to_euler_angles (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [qte_pkg::QIN_W-1:0]     i_quat_w,
    input  logic signed [qte_pkg::QIN_W-1:0]     i_quat_x,
    input  logic signed [qte_pkg::QIN_W-1:0]     i_quat_y,
    input  logic signed [qte_pkg::QIN_W-1:0]     i_quat_z,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_gyro_raw_x,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_gyro_raw_y,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_gyro_raw_z,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_accel_raw_x,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_accel_raw_y,
    input  logic signed [qte_pkg::RAW_W-1:0]     i_accel_raw_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [qte_pkg::ANG_W-1:0]     o_roll_angle,
    output logic signed [qte_pkg::PIT_W-1:0]     o_pitch_angle,
    output logic signed [qte_pkg::ANG_W-1:0]     o_yaw_angle,
    output logic signed [qte_pkg::RATE_W-1:0]    o_rate_x,
    output logic signed [qte_pkg::RATE_W-1:0]    o_rate_y,
    output logic signed [qte_pkg::RATE_W-1:0]    o_rate_z,
    output logic signed [qte_pkg::ACC_W-1:0]     o_accel_x_mg,
    output logic signed [qte_pkg::ACC_W-1:0]     o_accel_y_mg,
    output logic signed [qte_pkg::ACC_W-1:0]     o_accel_z_mg
);
    import qte_pkg::*;

    localparam int CDW    = 17;           // centidegree width before clamp
    localparam int ZWE    = ZW + 8;       // angle times 100
    localparam int GP_W   = RAW_W + 5;    // gyro times 25
    localparam int GM_W   = GP_W - 1;     // magnitude plus half divisor
    localparam int GQ_W   = 15;           // gyro quotient
    localparam int GPR_W  = GM_W + 27;    // reciprocal product
    localparam int AP_W   = RAW_W + 8;    // accel times 125
    localparam int AM_W   = AP_W - 1;

    // pair that the pitch normalization shifts together
    typedef struct packed {
        logic signed [PW-1:0] n;
        logic signed [PW-1:0] s;
    } t_ns;

    // one bit of the binary search for the shift that brings n2 below the bound
    function automatic t_ns ns_bit(input t_ns p, input int b);
        ns_bit = p;
        if ((p.n >>> ((1 << b) - 1)) >= OP_LIM) begin
            ns_bit.n = p.n >>> (1 << b);
            ns_bit.s = p.s >>> (1 << b);
        end
    endfunction

    function automatic logic signed [PW-1:0] clamp_w(input logic signed [PW-1:0] v,
                                                      input logic signed [PW-1:0] lim);
        if (v > lim) begin
            clamp_w = lim;
        end else if (v < -lim) begin
            clamp_w = -lim;
        end else begin
            clamp_w = v;
        end
    endfunction

    // degrees q16 to centidegrees, rounded half away from zero
    function automatic logic signed [CDW-1:0] cdeg(input logic signed [ZW-1:0] z);
        logic signed [ZWE-1:0] n;
        logic [ZWE-1:0]        m;
        logic signed [CDW-1:0] q;
        n = ZWE'(z) * ZWE'(100);
        m = ((n < 0) ? ZWE'(-n) : ZWE'(n)) + ZWE'(32768);
        q = CDW'(m >> 16);
        cdeg = (n < 0) ? -q : q;
    endfunction

    function automatic logic signed [CDW:0] clamp_c(input logic signed [CDW:0] v,
                                                     input logic signed [CDW:0] lim);
        if (v > lim) begin
            clamp_c = lim;
        end else if (v < -lim) begin
            clamp_c = -lim;
        end else begin
            clamp_c = v;
        end
    endfunction

    // pipe control: everything advances together
    logic             en;
    logic [TOTAL:1]   r_vld;

    assign en      = !r_vld[TOTAL] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[TOTAL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL-1:1], i_valid};
        end
    end

    // quaternion floored to q28
    logic signed [QW-1:0] qw, qx, qy, qz;
    assign qw = QW'(i_quat_w >>> 2);
    assign qx = QW'(i_quat_x >>> 2);
    assign qy = QW'(i_quat_y >>> 2);
    assign qz = QW'(i_quat_z >>> 2);

    // stage 1: products
    logic signed [MW-1:0] r_ww, r_xx, r_yy, r_zz, r_yz, r_wx, r_xy, r_wz, r_wy, r_xz;
    // stage 2: atan2 operands, squared norm and asin numerator
    logic signed [PW-1:0] r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_n2, r_s2;
    // stage 3: numerator clamped to the norm
    logic signed [PW-1:0] r_n3, r_s3;
    // stages 4 to 6: normalization search
    t_ns                  r_ns [SRCH];
    t_ns                  n_ns [SRCH];
    // stage 7 to 9: clamp, squares, radicand
    logic [OPB-1:0]       r_n7;
    logic signed [OPB:0]  r_s7, r_s8, r_s9;
    logic [SQW-1:0]       r_nn;
    logic signed [SQW:0]  r_ss;
    logic [SQW-1:0]       r_v;
    // stages 10 to 39: square root, one result bit a stage
    logic [SQW-1:0]       r_qv [ISQRT_STEPS];
    logic [SQW:0]         r_qr [ISQRT_STEPS];
    logic signed [OPB:0]  r_qs [ISQRT_STEPS];
    logic [SQW-1:0]       c_v  [ISQRT_STEPS];
    logic [SQW:0]         c_r  [ISQRT_STEPS];
    logic signed [OPB:0]  c_s  [ISQRT_STEPS];
    logic [SQW+1:0]       c_t  [ISQRT_STEPS];
    logic [SQW-1:0]       c_bit[ISQRT_STEPS];

    always_comb begin
        for (int s = 0; s < SRCH; s++) begin
            if (s == 0) begin
                n_ns[s] = ns_bit(ns_bit('{n: r_n3, s: r_s3}, 5), 4);
            end else begin
                n_ns[s] = ns_bit(ns_bit(r_ns[s-1], 5 - 2 * s), 4 - 2 * s);
            end
        end
        for (int j = 0; j < ISQRT_STEPS; j++) begin
            if (j == 0) begin
                c_v[j] = r_v;
                c_r[j] = '0;
                c_s[j] = r_s9;
            end else begin
                c_v[j] = r_qv[j-1];
                c_r[j] = r_qr[j-1];
                c_s[j] = r_qs[j-1];
            end
            c_bit[j] = SQW'(1) << (2 * (ISQRT_STEPS - 1 - j));
            c_t[j]   = (SQW+2)'(c_r[j]) + (SQW+2)'(c_bit[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= qw * qw;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_zz <= qz * qz;
            r_yz <= qy * qz;
            r_wx <= qw * qx;
            r_xy <= qx * qy;
            r_wz <= qw * qz;
            r_wy <= qw * qy;
            r_xz <= qx * qz;

            r_roll_y <= (PW'(r_yz) + PW'(r_wx)) <<< 1;
            r_roll_x <= PW'(r_ww) - PW'(r_xx) - PW'(r_yy) + PW'(r_zz);
            r_yaw_y  <= (PW'(r_xy) + PW'(r_wz)) <<< 1;
            r_yaw_x  <= PW'(r_ww) + PW'(r_xx) - PW'(r_yy) - PW'(r_zz);
            r_n2     <= PW'(r_ww) + PW'(r_xx) + PW'(r_yy) + PW'(r_zz);
            r_s2     <= (PW'(r_wy) - PW'(r_xz)) <<< 1;

            r_n3 <= r_n2;
            r_s3 <= clamp_w(r_s2, r_n2);

            for (int s = 0; s < SRCH; s++) begin
                r_ns[s] <= n_ns[s];
            end

            // floor shifts can leave the numerator one below minus the norm
            r_n7 <= OPB'(r_ns[SRCH-1].n);
            r_s7 <= (OPB+1)'(clamp_w(r_ns[SRCH-1].s, r_ns[SRCH-1].n));

            r_nn <= r_n7 * r_n7;
            r_ss <= r_s7 * r_s7;
            r_s8 <= r_s7;

            r_v  <= r_nn - r_ss[SQW-1:0];
            r_s9 <= r_s8;

            for (int j = 0; j < ISQRT_STEPS; j++) begin
                r_qs[j] <= c_s[j];
                if ((SQW+2)'(c_v[j]) >= c_t[j]) begin
                    r_qv[j] <= c_v[j] - SQW'(c_t[j]);
                    r_qr[j] <= (c_r[j] >> 1) + (SQW+1)'(c_bit[j]);
                end else begin
                    r_qv[j] <= c_v[j];
                    r_qr[j] <= c_r[j] >> 1;
                end
            end
        end
    end

    // atan2 units: roll and yaw start at stage 2, pitch after the square root
    logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;

    qte_cordic u_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_roll_x),
        .i_y   (r_roll_y),
        .o_z   (roll_z)
    );

    qte_cordic u_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_yaw_x),
        .i_y   (r_yaw_y),
        .o_z   (yaw_z)
    );

    qte_cordic u_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (PW'(r_qr[ISQRT_STEPS-1][OPB-1:0])),
        .i_y   (PW'(r_qs[ISQRT_STEPS-1])),
        .o_z   (pitch_z)
    );

    // roll and yaw wait for pitch
    logic signed [ZW-1:0]  r_rzd [RY_DLY];
    logic signed [ZW-1:0]  r_yzd [RY_DLY];
    logic signed [CDW-1:0] r_rc, r_pc, r_yc;
    logic signed [ANG_W-1:0] r_roll, r_yaw;
    logic signed [PIT_W-1:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < RY_DLY; k++) begin
                if (k == 0) begin
                    r_rzd[k] <= roll_z;
                    r_yzd[k] <= yaw_z;
                end else begin
                    r_rzd[k] <= r_rzd[k-1];
                    r_yzd[k] <= r_yzd[k-1];
                end
            end
            r_rc <= cdeg(r_rzd[RY_DLY-1]);
            r_pc <= cdeg(pitch_z);
            r_yc <= cdeg(r_yzd[RY_DLY-1]);
            // pitch and yaw are negated atan results
            r_roll  <= ANG_W'(clamp_c((CDW+1)'(r_rc), (CDW+1)'(ROLL_LIM)));
            r_pitch <= PIT_W'(clamp_c(-((CDW+1)'(r_pc)), (CDW+1)'(PITCH_LIM)));
            r_yaw   <= ANG_W'(clamp_c(-((CDW+1)'(r_yc)), (CDW+1)'(ROLL_LIM)));
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;

    // gyro and accel lanes: scaled in stages 1 to 3, then delayed to the output
    logic signed [RAW_W-1:0]  g_in [3];
    logic signed [RAW_W-1:0]  a_in [3];
    logic signed [GP_W-1:0]   g_p  [3];
    logic [GM_W-1:0]          n_gm1[3];
    logic [GM_W-1:0]          r_gm1[3], r_gm2[3];
    logic                     r_gn1[3], r_gn2[3];
    logic [GPR_W-1:0]         g_pr [3];
    logic [GQ_W-1:0]          r_gq2[3];
    logic [GM_W:0]            g_rem[3];
    logic signed [RATE_W-1:0] g_q  [3];
    logic signed [RATE_W-1:0] n_g3 [3];
    logic signed [RATE_W-1:0] r_g3 [3];
    logic signed [AP_W-1:0]   a_p  [3];
    logic [AM_W-1:0]          a_m  [3];
    logic signed [ACC_W-1:0]  a_q  [3];
    logic signed [ACC_W-1:0]  n_a1 [3];
    logic signed [ACC_W-1:0]  r_a1 [3], r_a2[3], r_a3[3];
    logic signed [RATE_W-1:0] r_gd [SIDE_DLY][3];
    logic signed [ACC_W-1:0]  r_ad [SIDE_DLY][3];

    assign g_in[0] = i_gyro_raw_x;
    assign g_in[1] = i_gyro_raw_y;
    assign g_in[2] = i_gyro_raw_z;
    assign a_in[0] = i_accel_raw_x;
    assign a_in[1] = i_accel_raw_y;
    assign a_in[2] = i_accel_raw_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // rate: round(g * 25 / 41) via reciprocal and one correction
            g_p[k]   = GP_W'(g_in[k]) * GP_W'(GYRO_NUM);
            n_gm1[k] = ((g_p[k] < 0) ? GM_W'(-g_p[k]) : GM_W'(g_p[k]))
                       + GM_W'(GYRO_DEN / 2);
            g_pr[k]  = GPR_W'(r_gm1[k]) * GPR_W'(RECIP41);
            g_rem[k] = (GM_W+1)'(r_gm2[k]) - (GM_W+1)'(r_gq2[k]) * (GM_W+1)'(GYRO_DEN);
            g_q[k]   = RATE_W'(r_gq2[k]) + RATE_W'(g_rem[k] >= (GM_W+1)'(GYRO_DEN));
            n_g3[k]  = r_gn2[k] ? -g_q[k] : g_q[k];
            // accel: round(a * 125 / 512)
            a_p[k]   = AP_W'(a_in[k]) * AP_W'(ACC_NUM);
            a_m[k]   = ((a_p[k] < 0) ? AM_W'(-a_p[k]) : AM_W'(a_p[k]))
                       + AM_W'(1 << (ACC_SH - 1));
            a_q[k]   = ACC_W'(a_m[k] >> ACC_SH);
            n_a1[k]  = (a_p[k] < 0) ? -a_q[k] : a_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_gm1[k] <= n_gm1[k];
                r_gn1[k] <= g_p[k] < 0;
                r_gm2[k] <= r_gm1[k];
                r_gn2[k] <= r_gn1[k];
                r_gq2[k] <= GQ_W'(g_pr[k] >> RECIP_SH);
                r_g3[k]  <= n_g3[k];
                r_a1[k]  <= n_a1[k];
                r_a2[k]  <= r_a1[k];
                r_a3[k]  <= r_a2[k];
                for (int d = 0; d < SIDE_DLY; d++) begin
                    if (d == 0) begin
                        r_gd[d][k] <= r_g3[k];
                        r_ad[d][k] <= r_a3[k];
                    end else begin
                        r_gd[d][k] <= r_gd[d-1][k];
                        r_ad[d][k] <= r_ad[d-1][k];
                    end
                end
            end
        end
    end

    assign o_rate_x     = r_gd[SIDE_DLY-1][0];
    assign o_rate_y     = r_gd[SIDE_DLY-1][1];
    assign o_rate_z     = r_gd[SIDE_DLY-1][2];
    assign o_accel_x_mg = r_ad[SIDE_DLY-1][0];
    assign o_accel_y_mg = r_ad[SIDE_DLY-1][1];
    assign o_accel_z_mg = r_ad[SIDE_DLY-1][2];

    // the pipe only blocks intake while a finished item waits
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("intake blocked without an output stall");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[1])
        else $error("accepted item lost at pipe entry");

    // stage valids never advance while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipe moved during stall");

    a_pitch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= PIT_W'(PITCH_LIM) && o_pitch_angle >= -PIT_W'(PITCH_LIM)))
        else $error("pitch out of range");

    a_rate_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rate_x <= RATE_W'(19981) && o_rate_x >= -RATE_W'(19981)))
        else $error("rate out of range");

endmodule
